// ===== rtl/rtpe_pkg.sv =====
package rtpe_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int VW = 6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RMW_A_RD,
        S_RMW_A_WR,
        S_RMW_B_RD,
        S_RMW_B_WR,
        S_LEAF,
        S_EDGE,
        S_EMIT,
        S_FSCAN,
        S_FREAD,
        S_FEMIT
    } state_t;

    typedef enum logic {
        DEG_INC,
        DEG_DEC
    } deg_op_t;

    typedef struct packed {
        deg_op_t        op;
        logic [VW-1:0]  cur;
    } deg_req_t;

endpackage

// ===== rtl/rtpe_if.sv =====
interface rtpe_in_if;
    logic                        valid;
    logic                        ready;
    logic [rtpe_pkg::VW-1:0]     vertex_a;
    logic [rtpe_pkg::VW-1:0]     vertex_b;
    logic                        last_edge;

    modport source (output valid, output vertex_a, output vertex_b, output last_edge,
                    input ready);
    modport sink (input valid, input vertex_a, input vertex_b, input last_edge,
                  output ready);
endinterface

interface rtpe_out_if;
    logic                        valid;
    logic                        ready;
    logic [rtpe_pkg::VW-1:0]     code_value;
    logic                        last_code;

    modport source (output valid, output code_value, output last_code, input ready);
    modport sink (input valid, input code_value, input last_code, output ready);
endinterface

// ===== rtl/rtpe_ram.sv =====
module rtpe_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/rtpe_deg_alu.sv =====
module rtpe_deg_alu (
    input  rtpe_pkg::deg_req_t          req,
    output logic [rtpe_pkg::VW-1:0]     result
);

    localparam logic [rtpe_pkg::VW-1:0] DEG_MAX = '1;

    // saturating count, floor at zero
    always_comb
    begin
        unique case (req.op)
            rtpe_pkg::DEG_INC:
            begin
                result = (req.cur == DEG_MAX) ? req.cur : req.cur + 1'b1;
            end
            rtpe_pkg::DEG_DEC:
            begin
                result = (req.cur == '0) ? req.cur : req.cur - 1'b1;
            end
            default:
            begin
                result = req.cur;
            end
        endcase
    end

endmodule

// ===== rtl/rooted_tree_prufer_encoder.sv =====
// Load: a transaction whose edge is dropped is taken in S_IDLE alone; a stored edge then runs
// an increment (read-modify-write) of both endpoint degrees. Encode, per emitted entry: leaf scan
// over the degree RAM for vertices 1 to min(MAX_VERTICES,64)-1, edge scan over the edge RAM, an emit
// step, then a decrement of both endpoint degrees. Final entry: live-flag scan, edge read, emit.
// Input is held off during encoding; the output register frees the sink side.
// Reset (rst_n low, asynchronous) empties the tree: no edges, all degrees zero.
module rooted_tree_prufer_encoder #(
    parameter int MAX_VERTICES = rtpe_pkg::MAX_VERTICES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rtpe_in_if.sink      edges,
    rtpe_out_if.source   codes
);

    localparam int VW    = rtpe_pkg::VW;
    localparam int NV    = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
    localparam int SLOTS = ((MAX_VERTICES - 1) < 63) ? (MAX_VERTICES - 1) : 63;
    localparam int AW    = $clog2(NV);
    localparam int EW    = $clog2(SLOTS);
    localparam int LW    = $clog2(SLOTS + 1);

    rtpe_pkg::state_t state_reg, state_next;

    logic [LW-1:0]    loaded_reg, loaded_next;
    logic [LW-1:0]    round_reg, round_next;
    logic [LW-1:0]    e_reg, e_next;
    logic [LW-1:0]    pe_reg, pe_next;
    logic [LW-1:0]    f_reg, f_next;
    logic [VW-1:0]    v_reg, v_next;
    logic [VW-1:0]    pv_reg, pv_next;
    logic             pend_reg, pend_next;
    logic             dec_mode_reg, dec_mode_next;
    logic [SLOTS-1:0] alive_reg, alive_next;
    logic [NV-1:0]    deg_valid_reg, deg_valid_next;
    logic [AW-1:0]    deg_rd_addr_reg, deg_rd_addr_next;
    logic             out_valid_reg, out_valid_next;

    logic [VW-1:0]    a_reg, a_next;
    logic [VW-1:0]    b_reg, b_next;
    logic             last_reg, last_next;
    logic [VW-1:0]    leaf_reg, leaf_next;
    logic [VW-1:0]    other_reg, other_next;
    logic [VW-1:0]    fin_reg, fin_next;
    logic [VW-1:0]    code_reg, code_next;
    logic             last_code_reg, last_code_next;

    logic                 edge_we, edge_re;
    logic [EW-1:0]        edge_waddr, edge_raddr;
    logic [2*VW-1:0]      edge_wdata, edge_rdata;
    logic                 deg_we, deg_re;
    logic [AW-1:0]        deg_waddr, deg_raddr;
    logic [VW-1:0]        deg_wdata, deg_rdata;

    rtpe_pkg::deg_req_t   alu_req;
    logic [VW-1:0]        alu_result;

    logic [VW-1:0]    deg_eff;
    logic [VW-1:0]    ea, eb;
    logic             accept, store_ok, out_free;
    logic             leaf_hit, leaf_end, edge_hit, edge_end, f_done, f_alive;

    rtpe_ram #(
        .WIDTH (2 * VW),
        .DEPTH (SLOTS)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    rtpe_ram #(
        .WIDTH (VW),
        .DEPTH (NV)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .re    (deg_re),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    rtpe_deg_alu u_deg_alu (
        .req    (alu_req),
        .result (alu_result)
    );

    assign ea       = edge_rdata[VW-1:0];
    assign eb       = edge_rdata[2*VW-1:VW];
    assign deg_eff  = deg_valid_reg[deg_rd_addr_reg] ? deg_rdata : '0;
    assign alu_req  = '{op: dec_mode_reg ? rtpe_pkg::DEG_DEC : rtpe_pkg::DEG_INC,
                        cur: deg_eff};

    assign accept   = (state_reg == rtpe_pkg::S_IDLE) && edges.valid;
    assign store_ok = (loaded_reg < LW'(SLOTS)) && (32'(edges.vertex_a) < MAX_VERTICES)
                      && (32'(edges.vertex_b) < MAX_VERTICES);
    assign out_free = !out_valid_reg || codes.ready;

    assign leaf_hit = pend_reg && (deg_eff == VW'(1));
    assign leaf_end = pend_reg && !leaf_hit && (pv_reg == VW'(NV - 1));
    assign edge_hit = pend_reg && alive_reg[pe_reg[EW-1:0]]
                      && ((ea == leaf_reg) || (eb == leaf_reg));
    assign edge_end = pend_reg && !edge_hit && ((pe_reg + LW'(1)) == loaded_reg);
    assign f_done   = !(f_reg < loaded_reg);
    assign f_alive  = alive_reg[f_reg[EW-1:0]];

    assign edges.ready      = (state_reg == rtpe_pkg::S_IDLE);
    assign codes.valid      = out_valid_reg;
    assign codes.code_value = code_reg;
    assign codes.last_code  = last_code_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtpe_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (store_ok)
                    begin
                        state_next = rtpe_pkg::S_RMW_A_RD;
                    end
                    else if (edges.last_edge)
                    begin
                        state_next = (loaded_reg > LW'(1)) ? rtpe_pkg::S_LEAF
                                                           : rtpe_pkg::S_FSCAN;
                    end
                end
            end
            rtpe_pkg::S_RMW_A_RD: state_next = rtpe_pkg::S_RMW_A_WR;
            rtpe_pkg::S_RMW_A_WR: state_next = rtpe_pkg::S_RMW_B_RD;
            rtpe_pkg::S_RMW_B_RD: state_next = rtpe_pkg::S_RMW_B_WR;
            rtpe_pkg::S_RMW_B_WR:
            begin
                if (dec_mode_reg)
                begin
                    state_next = ((round_reg + LW'(1)) < loaded_reg) ? rtpe_pkg::S_LEAF
                                                                      : rtpe_pkg::S_FSCAN;
                end
                else if (last_reg)
                begin
                    state_next = (loaded_reg > LW'(1)) ? rtpe_pkg::S_LEAF
                                                       : rtpe_pkg::S_FSCAN;
                end
                else
                begin
                    state_next = rtpe_pkg::S_IDLE;
                end
            end
            rtpe_pkg::S_LEAF:
            begin
                if (leaf_hit)
                begin
                    state_next = rtpe_pkg::S_EDGE;
                end
                else if (leaf_end)
                begin
                    state_next = rtpe_pkg::S_FSCAN;
                end
            end
            rtpe_pkg::S_EDGE:
            begin
                if (edge_hit)
                begin
                    state_next = rtpe_pkg::S_EMIT;
                end
                else if (edge_end)
                begin
                    state_next = rtpe_pkg::S_FSCAN;
                end
            end
            rtpe_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rtpe_pkg::S_RMW_A_RD;
                end
            end
            rtpe_pkg::S_FSCAN:
            begin
                if (f_done)
                begin
                    state_next = rtpe_pkg::S_FEMIT;
                end
                else if (f_alive)
                begin
                    state_next = rtpe_pkg::S_FREAD;
                end
            end
            rtpe_pkg::S_FREAD: state_next = rtpe_pkg::S_FEMIT;
            rtpe_pkg::S_FEMIT:
            begin
                if (out_free)
                begin
                    state_next = rtpe_pkg::S_IDLE;
                end
            end
            default: state_next = rtpe_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        loaded_next      = loaded_reg;
        round_next       = round_reg;
        e_next           = e_reg;
        pe_next          = pe_reg;
        f_next           = f_reg;
        v_next           = v_reg;
        pv_next          = pv_reg;
        pend_next        = pend_reg;
        dec_mode_next    = dec_mode_reg;
        alive_next       = alive_reg;
        deg_valid_next   = deg_valid_reg;
        deg_rd_addr_next = deg_rd_addr_reg;
        out_valid_next   = out_valid_reg && !codes.ready;
        a_next           = a_reg;
        b_next           = b_reg;
        last_next        = last_reg;
        leaf_next        = leaf_reg;
        other_next       = other_reg;
        fin_next         = fin_reg;
        code_next        = code_reg;
        last_code_next   = last_code_reg;

        edge_we    = 1'b0;
        edge_waddr = loaded_reg[EW-1:0];
        edge_wdata = {edges.vertex_b, edges.vertex_a};
        edge_re    = 1'b0;
        edge_raddr = e_reg[EW-1:0];
        deg_we     = 1'b0;
        deg_waddr  = a_reg[AW-1:0];
        deg_wdata  = alu_result;
        deg_re     = 1'b0;
        deg_raddr  = a_reg[AW-1:0];

        unique case (state_reg)
            rtpe_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    a_next        = edges.vertex_a;
                    b_next        = edges.vertex_b;
                    last_next     = edges.last_edge;
                    round_next    = LW'(1);
                    dec_mode_next = 1'b0;
                    if (store_ok)
                    begin
                        edge_we                        = 1'b1;
                        alive_next[loaded_reg[EW-1:0]] = 1'b1;
                        loaded_next                    = loaded_reg + LW'(1);
                    end
                end
            end
            rtpe_pkg::S_RMW_A_RD:
            begin
                deg_re = 1'b1;
            end
            rtpe_pkg::S_RMW_A_WR:
            begin
                deg_we                    = 1'b1;
                deg_valid_next[a_reg[AW-1:0]] = 1'b1;
            end
            rtpe_pkg::S_RMW_B_RD:
            begin
                deg_re    = 1'b1;
                deg_raddr = b_reg[AW-1:0];
            end
            rtpe_pkg::S_RMW_B_WR:
            begin
                deg_we                        = 1'b1;
                deg_waddr                     = b_reg[AW-1:0];
                deg_valid_next[b_reg[AW-1:0]] = 1'b1;
                if (dec_mode_reg)
                begin
                    round_next = round_reg + LW'(1);
                end
            end
            rtpe_pkg::S_LEAF:
            begin
                if (leaf_hit)
                begin
                    leaf_next = pv_reg;
                end
                else if (!leaf_end)
                begin
                    deg_re    = 1'b1;
                    deg_raddr = v_reg[AW-1:0];
                    pv_next   = v_reg;
                    v_next    = v_reg + VW'(1);
                    pend_next = 1'b1;
                end
            end
            rtpe_pkg::S_EDGE:
            begin
                if (edge_hit)
                begin
                    a_next                    = ea;
                    b_next                    = eb;
                    other_next                = (ea == leaf_reg) ? eb : ea;
                    alive_next[pe_reg[EW-1:0]] = 1'b0;
                end
                else if (edge_end)
                begin
                    // leaf count with no live edge: drop it
                    deg_valid_next[leaf_reg[AW-1:0]] = 1'b0;
                end
                else
                begin
                    edge_re   = 1'b1;
                    pe_next   = e_reg;
                    e_next    = e_reg + LW'(1);
                    pend_next = 1'b1;
                end
            end
            rtpe_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    code_next      = other_reg;
                    last_code_next = 1'b0;
                    dec_mode_next  = 1'b1;
                end
            end
            rtpe_pkg::S_FSCAN:
            begin
                if (f_done)
                begin
                    fin_next = '0;
                end
                else if (f_alive)
                begin
                    edge_re    = 1'b1;
                    edge_raddr = f_reg[EW-1:0];
                end
                else
                begin
                    f_next = f_reg + LW'(1);
                end
            end
            rtpe_pkg::S_FREAD:
            begin
                fin_next = (ea == '0) ? '0 : eb;
            end
            rtpe_pkg::S_FEMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    code_next      = fin_reg;
                    last_code_next = 1'b1;
                    loaded_next    = '0;
                    alive_next     = '0;
                    deg_valid_next = '0;
                    dec_mode_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (deg_re)
        begin
            deg_rd_addr_next = deg_raddr;
        end

        if ((state_next == rtpe_pkg::S_LEAF) && (state_reg != rtpe_pkg::S_LEAF))
        begin
            v_next    = VW'(1);
            pend_next = 1'b0;
        end
        if ((state_next == rtpe_pkg::S_EDGE) && (state_reg != rtpe_pkg::S_EDGE))
        begin
            e_next    = '0;
            pend_next = 1'b0;
        end
        if ((state_next == rtpe_pkg::S_FSCAN) && (state_reg != rtpe_pkg::S_FSCAN))
        begin
            f_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rtpe_pkg::S_IDLE;
            loaded_reg      <= '0;
            round_reg       <= '0;
            e_reg           <= '0;
            pe_reg          <= '0;
            f_reg           <= '0;
            v_reg           <= '0;
            pv_reg          <= '0;
            pend_reg        <= 1'b0;
            dec_mode_reg    <= 1'b0;
            alive_reg       <= '0;
            deg_valid_reg   <= '0;
            deg_rd_addr_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            loaded_reg      <= loaded_next;
            round_reg       <= round_next;
            e_reg           <= e_next;
            pe_reg          <= pe_next;
            f_reg           <= f_next;
            v_reg           <= v_next;
            pv_reg          <= pv_next;
            pend_reg        <= pend_next;
            dec_mode_reg    <= dec_mode_next;
            alive_reg       <= alive_next;
            deg_valid_reg   <= deg_valid_next;
            deg_rd_addr_reg <= deg_rd_addr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        last_reg      <= last_next;
        leaf_reg      <= leaf_next;
        other_reg     <= other_next;
        fin_reg       <= fin_next;
        code_reg      <= code_next;
        last_code_reg <= last_code_next;
    end

endmodule

// ===== tb/sv/tb_rooted_tree_prufer_encoder.sv =====
module tb_rooted_tree_prufer_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = rtpe_pkg::VW;
    localparam int MAXV = rtpe_pkg::MAX_VERTICES_DEF;
    localparam int SLOTS = ((MAXV - 1) < 63) ? (MAXV - 1) : 63;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;
    localparam int IDLE_PCT = 9;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          fin;
    } prufer_entry_t;

    typedef enum int {
        SHAPE_TREE,
        SHAPE_NOISE,
        SHAPE_BROKEN
    } tree_shape_t;

    logic clk = 1'b0;
    logic rst_n;

    rtpe_in_if  edges_if ();
    rtpe_out_if codes_if ();

    rooted_tree_prufer_encoder #(
        .MAX_VERTICES(MAXV)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .edges(edges_if),
        .codes(codes_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // encoder shadow state
    logic [VW-1:0] tree_a [SLOTS];
    logic [VW-1:0] tree_b [SLOTS];
    bit            tree_live [SLOTS];
    logic [5:0]    vdeg [MAXV];
    int            tree_edges;

    prufer_entry_t pending_codes [$];

    int  errors = 0;
    int  edges_sent = 0;
    int  quiet_cycles = 0;
    int  hold_len = 0;
    bit  steady = 1'b0;

    function automatic void clear_tree();
        for (int i = 0; i < SLOTS; i++)
        begin
            tree_a[i] = '0;
            tree_b[i] = '0;
            tree_live[i] = 1'b0;
        end
        for (int v = 0; v < MAXV; v++)
            vdeg[v] = '0;
        tree_edges = 0;
    endfunction

    function automatic void nudge_degree(input logic [VW-1:0] v, input bit up);
        if (v < MAXV)
        begin
            if (up && vdeg[v] < 63)
                vdeg[v]++;
            else if (!up && vdeg[v] > 0)
                vdeg[v]--;
        end
    endfunction

    // absorb one edge; on the last edge, push the whole Prufer sequence
    function automatic void encode_edge(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                        input logic last);
        int leaf;
        int e;
        prufer_entry_t ent;
        if (tree_edges < SLOTS && a < MAXV && b < MAXV)
        begin
            tree_a[tree_edges] = a;
            tree_b[tree_edges] = b;
            tree_live[tree_edges] = 1'b1;
            tree_edges++;
            nudge_degree(a, 1'b1);
            nudge_degree(b, 1'b1);
        end
        if (!last)
            return;
        for (int r = 1; r < tree_edges; r++)
        begin
            leaf = 0;
            for (int v = 1; v < MAXV && v < 64; v++)
            begin
                if (vdeg[v] == 1)
                begin
                    leaf = v;
                    break;
                end
            end
            if (leaf == 0)
                break;
            for (e = 0; e < tree_edges; e++)
            begin
                if (tree_live[e] && (tree_a[e] == leaf || tree_b[e] == leaf))
                    break;
            end
            if (e >= tree_edges)
            begin
                vdeg[leaf] = '0;
                break;
            end
            ent.value = (tree_a[e] == leaf) ? tree_b[e] : tree_a[e];
            ent.fin = 1'b0;
            pending_codes.push_back(ent);
            tree_live[e] = 1'b0;
            nudge_degree(tree_a[e], 1'b0);
            nudge_degree(tree_b[e], 1'b0);
        end
        ent.value = '0;
        ent.fin = 1'b1;
        for (e = 0; e < tree_edges; e++)
        begin
            if (tree_live[e])
            begin
                ent.value = (tree_a[e] == 0) ? '0 : tree_b[e];
                break;
            end
        end
        pending_codes.push_back(ent);
        clear_tree();
    endfunction

    // receiver: random stalls, optional long hold-off
    always @(negedge clk)
    begin
        if (hold_len > 0)
        begin
            codes_if.ready <= 1'b0;
            hold_len = hold_len - 1;
        end
        else if (steady)
            codes_if.ready <= 1'b1;
        else
            codes_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // predictor, result checker and watchdog
    always @(posedge clk)
    begin
        prufer_entry_t exp_ent;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (edges_if.valid && edges_if.ready)
            begin
                moved = 1'b1;
                encode_edge(edges_if.vertex_a, edges_if.vertex_b, edges_if.last_edge);
            end
            if (codes_if.valid && codes_if.ready)
            begin
                moved = 1'b1;
                if (pending_codes.size() == 0)
                begin
                    $error("unexpected code transaction: code_value %0d last_code %0d",
                           codes_if.code_value, codes_if.last_code);
                    errors++;
                end
                else
                begin
                    exp_ent = pending_codes.pop_front();
                    if (codes_if.code_value !== exp_ent.value)
                    begin
                        $error("code_value expected %0d actual %0d",
                               exp_ent.value, codes_if.code_value);
                        errors++;
                    end
                    if (codes_if.last_code !== exp_ent.fin)
                    begin
                        $error("last_code expected %0d actual %0d",
                               exp_ent.fin, codes_if.last_code);
                        errors++;
                    end
                end
            end
            if (moved)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_edge(input logic [VW-1:0] a, input logic [VW-1:0] b,
                             input logic last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            edges_if.valid <= 1'b0;
            @(negedge clk);
        end
        edges_if.valid <= 1'b1;
        edges_if.vertex_a <= a;
        edges_if.vertex_b <= b;
        edges_if.last_edge <= last;
        @(posedge clk);
        while (!edges_if.ready)
            @(posedge clk);
        edges_sent++;
        @(negedge clk);
    endtask

    task automatic send_tree(input int n, input tree_shape_t shape);
        logic [VW-1:0] label [64];
        logic [VW-1:0] ea [$];
        logic [VW-1:0] eb [$];
        logic [VW-1:0] t;
        int j;
        for (int i = 0; i <= n; i++)
            label[i] = VW'(i);
        for (int i = n; i > 1; i--)
        begin
            j = $urandom_range(1, i);
            t = label[i];
            label[i] = label[j];
            label[j] = t;
        end
        for (int i = 1; i <= n; i++)
        begin
            j = $urandom_range(0, i - 1);
            if ($urandom_range(0, 1))
            begin
                ea.push_back(label[i]);
                eb.push_back(label[j]);
            end
            else
            begin
                ea.push_back(label[j]);
                eb.push_back(label[i]);
            end
        end
        for (int i = ea.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = ea[i];
            ea[i] = ea[j];
            ea[j] = t;
            t = eb[i];
            eb[i] = eb[j];
            eb[j] = t;
        end
        if (shape == SHAPE_NOISE)
        begin
            for (int i = 0; i < ea.size(); i++)
            begin
                ea[i] = VW'($urandom_range(0, 63));
                eb[i] = VW'($urandom_range(0, 63));
            end
        end
        else if (shape == SHAPE_BROKEN)
        begin
            j = $urandom_range(0, ea.size() - 1);
            if (ea.size() > 1 && $urandom_range(0, 1))
            begin
                ea.delete(j);
                eb.delete(j);
            end
            else
            begin
                ea.push_back(ea[j]);
                eb.push_back(eb[j]);
            end
        end
        for (int i = 0; i < ea.size(); i++)
            send_edge(ea[i], eb[i], i == ea.size() - 1);
    endtask

    task automatic drain_codes(input int settle);
        edges_if.valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_edge(6'd0, 6'd1, 1'b1);
        send_edge(6'd63, 6'd0, 1'b1);
        send_edge(6'd0, 6'd63, 1'b0);
        send_edge(6'd63, 6'd62, 1'b1);
        for (int i = 1; i <= 5; i++)
            send_edge(6'd0, VW'(i), i == 5);
        // path given leaf first, endpoints reversed
        send_edge(6'd4, 6'd3, 1'b0);
        send_edge(6'd2, 6'd3, 1'b0);
        send_edge(6'd2, 6'd1, 1'b0);
        send_edge(6'd0, 6'd1, 1'b1);
        // cycle: no leaf, final entry at once
        send_edge(6'd1, 6'd2, 1'b0);
        send_edge(6'd2, 6'd3, 1'b0);
        send_edge(6'd3, 6'd1, 1'b1);
        send_edge(6'd5, 6'd5, 1'b1);
        send_edge(6'd0, 6'd42, 1'b0);
        send_edge(6'd42, 6'd21, 1'b1);
        send_edge(6'd21, 6'd0, 1'b1);
    endtask

    task automatic test_store_full();
        // 63 stored edges, then a dropped one that still closes the tree
        for (int i = 1; i <= 63; i++)
            send_edge(6'd0, VW'(i), 1'b0);
        send_edge(6'd5, 6'd9, 1'b1);
    endtask

    task automatic test_degree_saturation();
        for (int i = 0; i < 32; i++)
            send_edge(6'd7, 6'd7, 1'b0);
        send_edge(6'd7, 6'd1, 1'b1);
        send_tree(63, SHAPE_TREE);
    endtask

    task automatic test_random_trees();
        int start;
        int pick;
        int n;
        start = edges_sent;
        while (edges_sent - start < 80)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                n = $urandom_range(1, 6);
            else if (pick < 95)
                n = $urandom_range(7, 20);
            else
                n = $urandom_range(21, 63);
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_tree(n, SHAPE_TREE);
            else if (pick < 90)
                send_tree($urandom_range(1, 8), SHAPE_NOISE);
            else
                send_tree(n, SHAPE_BROKEN);
        end
    endtask

    task automatic test_receiver_holdoff();
        hold_len = 400;
        send_tree(12, SHAPE_TREE);
        send_tree(5, SHAPE_TREE);
        send_tree(30, SHAPE_TREE);
    endtask

    task automatic test_sender_pause();
        send_tree(8, SHAPE_TREE);
        drain_codes(100);
        send_tree(3, SHAPE_TREE);
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        for (int i = 0; i < 8; i++)
            send_tree($urandom_range(1, 9), SHAPE_TREE);
        steady = 1'b0;
    endtask

    initial
    begin
        clear_tree();
        rst_n = 1'b0;
        edges_if.valid = 1'b0;
        edges_if.vertex_a = '0;
        edges_if.vertex_b = '0;
        edges_if.last_edge = 1'b0;
        codes_if.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_store_full();
        test_degree_saturation();
        test_receiver_holdoff();
        test_sender_pause();
        test_steady_stream();
        test_random_trees();

        drain_codes(SETTLE_CYCLES);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
